### src/uierf_pkg.sv
package uierf_pkg;

	typedef enum logic [2:0] {
		CFG_STATION_MAC = 3'd0,
		CFG_SOURCE_IP   = 3'd1,
		CFG_DEST_IP     = 3'd2,
		CFG_DEST_PORT   = 3'd3,
		CFG_CAPTURE_LIM = 3'd4
	} cfg_index_t;

	typedef enum logic [1:0] {
		VERDICT_ACCEPT = 2'd0,
		VERDICT_ETH    = 2'd1,
		VERDICT_IP     = 2'd2,
		VERDICT_UDP    = 2'd3
	} verdict_t;

	localparam logic [7:0]  PROTO_UDP     = 8'd17;
	localparam logic [7:0]  ETH_TYPE_HI   = 8'h08;
	localparam logic [7:0]  ETH_TYPE_LO   = 8'h00;
	localparam logic [31:0] IP_ANY        = 32'h0000_0000;
	localparam logic [31:0] IP_BROADCAST  = 32'hffff_ffff;
	localparam logic [7:0]  BCAST_BYTE    = 8'hff;

	// Item handed from the byte front end to the verdict back end.
	typedef struct packed {
		logic [15:0] pos;
		logic        eth_fail;
		logic [1:0]  mac_flags;
		logic        ip_fail;
		logic [3:0]  hdr_words;
		logic [19:0] ip_sum;
		logic [15:0] ip_check;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [31:0] udp_sum;
		logic [15:0] udp_len;
		logic [15:0] udp_check;
		logic [15:0] dst_port;
		logic [47:0] sender_mac;
		logic [15:0] sender_port;
	} frame_sum_t;

	function automatic logic [15:0] fold_cpl(input logic [31:0] s);
		logic [31:0] t;
		t = {16'd0, s[31:16]} + {16'd0, s[15:0]};
		t = t + {16'd0, t[31:16]};
		return ~t[15:0];
	endfunction

endpackage

### src/uierf_if.sv
interface uierf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       end_of_frame;
	modport source (output valid, frame_byte, end_of_frame, input ready);
	modport sink (input valid, frame_byte, end_of_frame, output ready);
endinterface

interface uierf_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  verdict;
	logic [47:0] sender_mac;
	logic [31:0] sender_ip;
	logic [15:0] sender_port;
	logic [6:0]  payload_offset;
	logic [15:0] payload_length;
	modport source (output valid, verdict, sender_mac, sender_ip, sender_port,
		payload_offset, payload_length, input ready);
	modport sink (input valid, verdict, sender_mac, sender_ip, sender_port,
		payload_offset, payload_length, output ready);
endinterface

interface uierf_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [47:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### src/uierf_front.sv
module uierf_front #(
	parameter int MAX_CAPTURE = 2048
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [7:0]              in_byte,
	input  logic                    in_last,
	input  logic [47:0]             station_mac,
	input  logic [11:0]             capture_limit,
	output uierf_pkg::frame_sum_t   sum_d,
	output logic                    sum_valid
);
	import uierf_pkg::*;

	localparam int PW = $clog2(MAX_CAPTURE + 1);

	logic [PW-1:0] pos_q;
	logic [1:0]  mac_q;
	logic        eth_fail_q, ip_fail_q;
	logic [3:0]  hw_q;
	logic [19:0] ip_sum_q;
	logic [15:0] ip_chk_q, udp_len_q, udp_chk_q, dport_q, sport_q;
	logic [31:0] udp_sum_q, src_q, dst_q;
	logic [47:0] smac_q;

	logic [PW-1:0] limit;
	logic        take;
	logic [15:0] w;
	logic [15:0] p16;
	logic [15:0] u;
	logic [15:0] k;
	logic [7:0]  want;
	frame_sum_t  nx;

	always_comb begin
		if ({4'd0, capture_limit} > 16'(MAX_CAPTURE)) limit = PW'(MAX_CAPTURE);
		else limit = PW'(capture_limit);
		take = pos_q < limit;
		p16 = 16'(pos_q);
		w = p16[0] ? {8'd0, in_byte} : {in_byte, 8'd0};
		u = 16'd14 + {10'd0, hw_q, 2'b00};
		k = p16 - u;
		want = 8'h00;
		for (int i = 0; i < 6; i++)
			if (p16 == 16'(i)) want = station_mac[8*(5-i) +: 8];

		nx.pos = p16; nx.eth_fail = eth_fail_q; nx.mac_flags = mac_q;
		nx.ip_fail = ip_fail_q; nx.hdr_words = hw_q; nx.ip_sum = ip_sum_q;
		nx.ip_check = ip_chk_q; nx.src_addr = src_q; nx.dst_addr = dst_q;
		nx.udp_sum = udp_sum_q; nx.udp_len = udp_len_q; nx.udp_check = udp_chk_q;
		nx.dst_port = dport_q; nx.sender_mac = smac_q; nx.sender_port = sport_q;

		if (take) begin
			nx.pos = p16 + 16'd1;
			if (p16 < 16'd6) begin
				if (in_byte != want) nx.mac_flags[0] = 1'b0;
				if (in_byte != BCAST_BYTE) nx.mac_flags[1] = 1'b0;
			end else if (p16 < 16'd12) begin
				nx.sender_mac[8*(11-p16[3:0]) +: 8] = in_byte;
			end else if (p16 == 16'd12) begin
				if (in_byte != ETH_TYPE_HI) nx.eth_fail = 1'b1;
			end else if (p16 == 16'd13) begin
				if (in_byte != ETH_TYPE_LO) nx.eth_fail = 1'b1;
			end else if (p16 < 16'd34) begin
				if (p16 == 16'd14) begin
					if (in_byte[7:4] != 4'd4 || in_byte[3:0] < 4'd5) nx.ip_fail = 1'b1;
					nx.hdr_words = in_byte[3:0];
				end
				if (p16 == 16'd23 && in_byte != PROTO_UDP) nx.ip_fail = 1'b1;
				if (p16 == 16'd24 || p16 == 16'd25) nx.ip_check = ip_chk_q | w;
				else nx.ip_sum = ip_sum_q + {4'd0, w};
				if (p16 >= 16'd26 && p16 < 16'd30) begin
					nx.src_addr = {src_q[23:0], in_byte};
					nx.udp_sum = udp_sum_q + {16'd0, w};
				end
				if (p16 >= 16'd30) begin
					nx.dst_addr = {dst_q[23:0], in_byte};
					nx.udp_sum = udp_sum_q + {16'd0, w};
				end
			end else if (hw_q >= 4'd5) begin
				if (p16 >= u && p16 < u + 16'd8) begin
					if (k < 16'd2) nx.sender_port = sport_q | w;
					else if (k < 16'd4) nx.dst_port = dport_q | w;
					else if (k < 16'd6) nx.udp_len = udp_len_q | w;
					else nx.udp_check = udp_chk_q | w;
					if (k < 16'd6) nx.udp_sum = udp_sum_q + {16'd0, w};
				end else if (p16 >= u + 16'd8 && udp_len_q >= 16'd8
						&& {1'b0, p16} < {1'b0, u} + {1'b0, udp_len_q}) begin
					nx.udp_sum = udp_sum_q + {16'd0, w};
				end
			end
		end
	end

	assign sum_d = nx;
	assign sum_valid = in_valid && in_last;

	// Advance per-frame state on every byte; clear after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; mac_q <= 2'b11; eth_fail_q <= 1'b0; ip_fail_q <= 1'b0;
			hw_q <= '0; ip_sum_q <= '0; ip_chk_q <= '0; src_q <= '0; dst_q <= '0;
			udp_sum_q <= '0; udp_len_q <= '0; udp_chk_q <= '0; dport_q <= '0;
			smac_q <= '0; sport_q <= '0;
		end else if (in_valid) begin
			if (in_last) begin
				pos_q <= '0; mac_q <= 2'b11; eth_fail_q <= 1'b0; ip_fail_q <= 1'b0;
				hw_q <= '0; ip_sum_q <= '0; ip_chk_q <= '0; src_q <= '0;
				dst_q <= '0; udp_sum_q <= '0; udp_len_q <= '0; udp_chk_q <= '0;
				dport_q <= '0; smac_q <= '0; sport_q <= '0;
			end else begin
				pos_q <= PW'(nx.pos); mac_q <= nx.mac_flags;
				eth_fail_q <= nx.eth_fail; ip_fail_q <= nx.ip_fail;
				hw_q <= nx.hdr_words; ip_sum_q <= nx.ip_sum; ip_chk_q <= nx.ip_check;
				src_q <= nx.src_addr; dst_q <= nx.dst_addr; udp_sum_q <= nx.udp_sum;
				udp_len_q <= nx.udp_len; udp_chk_q <= nx.udp_check;
				dport_q <= nx.dst_port; smac_q <= nx.sender_mac;
				sport_q <= nx.sender_port;
			end
		end
	end
endmodule

### src/uierf_fifo.sv
module uierf_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  uierf_pkg::frame_sum_t push_data,
	output logic                  full,
	input  logic                  pop,
	output logic                  not_empty,
	output uierf_pkg::frame_sum_t pop_data
);
	import uierf_pkg::*;

	frame_sum_t mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;

	assign full = cnt_q == 3'd4;
	assign not_empty = cnt_q != 3'd0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, push} - {2'd0, pop};
		end
	end
endmodule

### src/uierf_back.sv
module uierf_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  uierf_pkg::frame_sum_t q_data,
	output logic                  q_pop,
	input  logic [31:0]           source_ip_filter,
	input  logic [31:0]           dest_ip_filter,
	input  logic [15:0]           dest_port_filter,
	output logic                  valid,
	input  logic                  ready,
	output logic [1:0]            verdict,
	output logic [47:0]           sender_mac,
	output logic [31:0]           sender_ip,
	output logic [15:0]           sender_port,
	output logic [6:0]            payload_offset,
	output logic [15:0]           payload_length
);
	import uierf_pkg::*;

	// Stage 1: fold sums and compare; stage 2: output register.
	frame_sum_t s_s1;
	logic       v_s1;
	logic [15:0] ipf_s1, udpf_s1;
	logic [16:0] u_s1;
	logic        adv1, adv2;
	verdict_t    vd;

	assign adv2 = !valid || ready;
	assign adv1 = !v_s1 || adv2;
	assign q_pop = q_valid && adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv1) v_s1 <= q_valid;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			s_s1 <= q_data;
			ipf_s1 <= fold_cpl({12'd0, q_data.ip_sum});
			udpf_s1 <= fold_cpl(q_data.udp_sum + 32'(PROTO_UDP) + {16'd0, q_data.udp_len});
			u_s1 <= 17'd14 + {11'd0, q_data.hdr_words, 2'b00};
		end
	end

	always_comb begin
		if (s_s1.pos < 16'd14 || s_s1.eth_fail || s_s1.mac_flags == 2'b00)
			vd = VERDICT_ETH;
		else if (s_s1.pos < 16'd34 || s_s1.ip_fail || s_s1.hdr_words < 4'd5)
			vd = VERDICT_IP;
		else if (s_s1.ip_check != 16'd0 && ipf_s1 != s_s1.ip_check) vd = VERDICT_IP;
		else if (source_ip_filter != IP_ANY && s_s1.src_addr != source_ip_filter)
			vd = VERDICT_IP;
		else if (dest_ip_filter != IP_BROADCAST && s_s1.dst_addr != dest_ip_filter)
			vd = VERDICT_IP;
		else if ({1'b0, s_s1.pos} < u_s1 + 17'd8 || s_s1.udp_len < 16'd8
				|| {1'b0, s_s1.pos} < u_s1 + {1'b0, s_s1.udp_len})
			vd = VERDICT_UDP;
		else if (udpf_s1 != s_s1.udp_check) vd = VERDICT_UDP;
		else if (s_s1.dst_port != dest_port_filter) vd = VERDICT_UDP;
		else vd = VERDICT_ACCEPT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else if (adv2) begin
			valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			verdict <= vd;
			if (vd == VERDICT_ACCEPT) begin
				sender_mac <= s_s1.sender_mac;
				sender_ip <= s_s1.src_addr;
				sender_port <= s_s1.sender_port;
				payload_offset <= 7'(u_s1 + 17'd8);
				payload_length <= s_s1.udp_len - 16'd8;
			end else begin
				sender_mac <= '0; sender_ip <= '0; sender_port <= '0;
				payload_offset <= '0; payload_length <= '0;
			end
		end
	end
endmodule

### src/udp_ipv4_ethernet_rx_filter.sv
// Channel  Dir  Payload                                   Handshake
// in       in   frame_byte[8], end_of_frame               valid/ready
// out      out  verdict, sender_mac/ip/port, offset, len  valid/ready
// cfg      in   index[3], data[48]                        valid/ready
//
// One frame byte is taken each cycle while the queue has room; the front end
// registers per-frame state on each byte. On the last byte a summary enters a
// 4-deep queue; the back end folds checksums (one stage) and registers the
// result (one stage). Reset clears all control and per-frame state and loads
// register defaults. Input stalls only when the queue is full, i.e. many short
// frames pile up behind a stalled output; configuration is always taken.
module udp_ipv4_ethernet_rx_filter #(
	parameter int MAX_CAPTURE = 2048
) (
	input logic       clk,
	input logic       arst_n,
	uierf_in_if.sink  in_ch,
	uierf_out_if.source out_ch,
	uierf_cfg_if.sink cfg
);
	import uierf_pkg::*;

	logic [47:0] station_mac_q;
	logic [31:0] source_ip_q, dest_ip_q;
	logic [15:0] dest_port_q;
	logic [11:0] capture_limit_q;

	// Accept register writes unconditionally.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_mac_q <= '0;
			source_ip_q <= IP_ANY;
			dest_ip_q <= IP_BROADCAST;
			dest_port_q <= 16'd67;
			capture_limit_q <= 12'd1514;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_STATION_MAC: station_mac_q <= cfg.data;
				CFG_SOURCE_IP:   source_ip_q <= cfg.data[31:0];
				CFG_DEST_IP:     dest_ip_q <= cfg.data[31:0];
				CFG_DEST_PORT:   dest_port_q <= cfg.data[15:0];
				CFG_CAPTURE_LIM: capture_limit_q <= cfg.data[11:0];
				default: ;
			endcase
		end
	end

	frame_sum_t sum_d, q_data;
	logic sum_valid, q_full, q_pop, q_valid, in_acc;

	// Hold input while the queue cannot take another frame summary.
	assign in_ch.ready = !q_full;
	assign in_acc = in_ch.valid && in_ch.ready;

	uierf_front #(.MAX_CAPTURE(MAX_CAPTURE)) u_front (
		.clk, .arst_n, .in_valid(in_acc), .in_byte(in_ch.frame_byte),
		.in_last(in_ch.end_of_frame), .station_mac(station_mac_q),
		.capture_limit(capture_limit_q), .sum_d, .sum_valid
	);

	uierf_fifo u_fifo (
		.clk, .arst_n, .push(sum_valid), .push_data(sum_d), .full(q_full),
		.pop(q_pop), .not_empty(q_valid), .pop_data(q_data)
	);

	uierf_back u_back (
		.clk, .arst_n, .q_valid, .q_data, .q_pop,
		.source_ip_filter(source_ip_q), .dest_ip_filter(dest_ip_q),
		.dest_port_filter(dest_port_q),
		.valid(out_ch.valid), .ready(out_ch.ready), .verdict(out_ch.verdict),
		.sender_mac(out_ch.sender_mac), .sender_ip(out_ch.sender_ip),
		.sender_port(out_ch.sender_port), .payload_offset(out_ch.payload_offset),
		.payload_length(out_ch.payload_length)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(sum_valid && q_full)) else $error("push into full queue");
	a_accept_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.verdict != VERDICT_ACCEPT |-> out_ch.sender_ip == 32'd0
		&& out_ch.payload_offset == 7'd0) else $error("reject carries fields");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
endmodule

### bench/udp_ipv4_ethernet_rx_filter_checker.sv
module udp_ipv4_ethernet_rx_filter_checker
	import uierf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	uierf_in_if.sink in_mon,
	uierf_out_if.sink out_mon,
	uierf_cfg_if.sink cfg_mon,
	output int fail_count,
	output int verdicts_pending
);
	typedef struct {
		verdict_t    verdict;
		logic [47:0] sender_mac;
		logic [31:0] sender_ip;
		logic [15:0] sender_port;
		logic [6:0]  payload_offset;
		logic [15:0] payload_length;
	} verdict_rec_t;

	verdict_rec_t verdict_q[$];

	logic [47:0] own_mac;
	logic [31:0] src_filter, dst_filter;
	logic [15:0] port_filter;
	logic [11:0] cap_limit;

	int          pos;
	logic [1:0]  mac_ok;
	logic        eth_bad, ip_bad;
	logic [31:0] ipsum, usum, saddr, daddr;
	logic [15:0] ipchk, ulen, uchk, dport, sport;
	logic [3:0]  ihl;
	logic [47:0] smac;

	assign verdicts_pending = verdict_q.size();

	function automatic logic [15:0] csum_fold(input logic [31:0] s);
		logic [31:0] t;
		t = (s >> 16) + (s & 32'hffff);
		t = t + (t >> 16);
		return ~t[15:0];
	endfunction

	task automatic clear_frame();
		pos = 0; mac_ok = 2'b11; eth_bad = 0; ip_bad = 0;
		ipsum = 0; usum = 0; saddr = 0; daddr = 0; ipchk = 0;
		ulen = 0; uchk = 0; dport = 0; sport = 0; ihl = 0; smac = 0;
	endtask

	task automatic absorb_byte(input int p, input logic [7:0] b);
		logic [15:0] w;
		int u, k;
		w = p[0] ? {8'd0, b} : {b, 8'd0};
		if (p < 6) begin
			if (b != own_mac[47 - 8*p -: 8]) mac_ok[0] = 0;
			if (b != BCAST_BYTE) mac_ok[1] = 0;
		end else if (p < 12) begin
			smac[47 - 8*(p-6) -: 8] = b;
		end else if (p == 12) begin
			if (b != ETH_TYPE_HI) eth_bad = 1;
		end else if (p == 13) begin
			if (b != ETH_TYPE_LO) eth_bad = 1;
		end else if (p < 34) begin
			if (p == 14) begin
				if (b[7:4] != 4) ip_bad = 1;
				ihl = b[3:0];
				if (ihl < 5) ip_bad = 1;
			end
			if (p == 23 && b != PROTO_UDP) ip_bad = 1;
			if (p == 24 || p == 25) ipchk |= w;
			else ipsum += w;
			if (p >= 26 && p < 30) begin saddr = {saddr[23:0], b}; usum += w; end
			if (p >= 30) begin daddr = {daddr[23:0], b}; usum += w; end
		end else if (ihl >= 5) begin
			u = 14 + 4*ihl;
			if (p >= u && p < u + 8) begin
				k = p - u;
				if (k < 2) sport |= w;
				else if (k < 4) dport |= w;
				else if (k < 6) ulen |= w;
				else uchk |= w;
				if (k < 6) usum += w;
			end else if (p >= u + 8 && ulen >= 8 && p < u + ulen) begin
				usum += w;
			end
		end
	endtask

	function automatic verdict_t judge_frame();
		int u;
		if (pos < 14 || eth_bad || mac_ok == 0) return VERDICT_ETH;
		if (pos < 34 || ip_bad || ihl < 5) return VERDICT_IP;
		if (ipchk != 0 && csum_fold(ipsum) != ipchk) return VERDICT_IP;
		if (src_filter != IP_ANY && saddr != src_filter) return VERDICT_IP;
		if (dst_filter != IP_BROADCAST && daddr != dst_filter) return VERDICT_IP;
		u = 14 + 4*ihl;
		if (pos < u + 8 || ulen < 8 || pos < u + ulen) return VERDICT_UDP;
		if (csum_fold(usum + PROTO_UDP + ulen) != uchk) return VERDICT_UDP;
		if (dport != port_filter) return VERDICT_UDP;
		return VERDICT_ACCEPT;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_rec_t r, got;
		int lim;
		if (!arst_n) begin
			own_mac = 0; src_filter = IP_ANY; dst_filter = IP_BROADCAST;
			port_filter = 16'd67; cap_limit = 12'd1514;
			clear_frame();
			verdict_q.delete();
			fail_count <= 0;
		end else begin
			if (out_mon.valid && out_mon.ready) begin
				if (verdict_q.size() == 0) begin
					$error("unexpected verdict %0d", out_mon.verdict);
					fail_count <= fail_count + 1;
				end else begin
					r = verdict_q.pop_front();
					if (out_mon.verdict !== r.verdict || out_mon.sender_mac !== r.sender_mac
						|| out_mon.sender_ip !== r.sender_ip
						|| out_mon.sender_port !== r.sender_port
						|| out_mon.payload_offset !== r.payload_offset
						|| out_mon.payload_length !== r.payload_length) begin
						fail_count <= fail_count + 1;
						if (out_mon.verdict !== r.verdict)
							$error("verdict: expected %0d actual %0d", r.verdict,
								out_mon.verdict);
						if (out_mon.sender_mac !== r.sender_mac)
							$error("sender_mac: expected %h actual %h", r.sender_mac,
								out_mon.sender_mac);
						if (out_mon.sender_ip !== r.sender_ip)
							$error("sender_ip: expected %h actual %h", r.sender_ip,
								out_mon.sender_ip);
						if (out_mon.sender_port !== r.sender_port)
							$error("sender_port: expected %h actual %h", r.sender_port,
								out_mon.sender_port);
						if (out_mon.payload_offset !== r.payload_offset)
							$error("payload_offset: expected %0d actual %0d",
								r.payload_offset, out_mon.payload_offset);
						if (out_mon.payload_length !== r.payload_length)
							$error("payload_length: expected %0d actual %0d",
								r.payload_length, out_mon.payload_length);
					end
				end
			end
			if (in_mon.valid && in_mon.ready) begin
				lim = (cap_limit > 2048) ? 2048 : cap_limit;
				if (pos < lim) begin
					absorb_byte(pos, in_mon.frame_byte);
					pos++;
				end
				if (in_mon.end_of_frame) begin
					got.verdict = judge_frame();
					got.sender_mac = 0; got.sender_ip = 0; got.sender_port = 0;
					got.payload_offset = 0; got.payload_length = 0;
					if (got.verdict == VERDICT_ACCEPT) begin
						got.sender_mac = smac;
						got.sender_ip = saddr;
						got.sender_port = sport;
						got.payload_offset = 7'(14 + 4*ihl + 8);
						got.payload_length = ulen - 16'd8;
					end
					verdict_q.push_back(got);
					clear_frame();
				end
			end
			if (cfg_mon.valid && cfg_mon.ready) begin
				case (cfg_index_t'(cfg_mon.index))
					CFG_STATION_MAC: own_mac = cfg_mon.data;
					CFG_SOURCE_IP:   src_filter = cfg_mon.data[31:0];
					CFG_DEST_IP:     dst_filter = cfg_mon.data[31:0];
					CFG_DEST_PORT:   port_filter = cfg_mon.data[15:0];
					CFG_CAPTURE_LIM: cap_limit = cfg_mon.data[11:0];
					default: ;
				endcase
			end
		end
	end
endmodule

### bench/udp_ipv4_ethernet_rx_filter_tb.sv
module udp_ipv4_ethernet_rx_filter_tb;
	import uierf_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	int   fail_count, verdicts_pending;
	int   cycle_count = 0;
	// idle percentages for the sender and the receiver
	int   send_idle_pct = 20, recv_idle_pct = 81;

	uierf_in_if  in_ch();
	uierf_out_if out_ch();
	uierf_cfg_if cfg_ch();

	udp_ipv4_ethernet_rx_filter dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg_ch)
	);

	udp_ipv4_ethernet_rx_filter_checker chk (
		.clk(clk), .arst_n(arst_n), .in_mon(in_ch), .out_mon(out_ch),
		.cfg_mon(cfg_ch), .fail_count(fail_count), .verdicts_pending(verdicts_pending)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// Bound the run; the slowest legal run is far below this.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Drive the receiver's ready at random per the current idle rate.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_ch.ready <= 0;
		else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Current frame being assembled, sent byte by byte.
	logic [7:0] frame_buf[$];
	logic [47:0] cur_mac;
	logic [31:0] cur_src, cur_dst;
	logic [15:0] cur_port;
	logic [11:0] cur_limit;

	task automatic push_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 0;
			@(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.frame_byte <= b;
		in_ch.end_of_frame <= last;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic send_frame();
		int n;
		n = frame_buf.size();
		if (n == 0) begin
			push_byte($urandom_range(255), 1);
		end else begin
			for (int i = 0; i < n; i++) push_byte(frame_buf[i], i == n - 1);
		end
		in_ch.valid <= 0;
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [47:0] val);
		cfg_ch.valid <= 1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 0;
		case (idx)
			CFG_STATION_MAC: cur_mac = val;
			CFG_SOURCE_IP:   cur_src = val[31:0];
			CFG_DEST_IP:     cur_dst = val[31:0];
			CFG_DEST_PORT:   cur_port = val[15:0];
			default:         cur_limit = val[11:0];
		endcase
	endtask

	// Let the checker see the last accepted byte, hold until every verdict
	// has arrived, then let the pipeline drain.
	task automatic drain();
		@(posedge clk);
		while (verdicts_pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [15:0] fold16(input logic [31:0] s);
		s = (s >> 16) + (s & 32'hffff);
		s = s + (s >> 16);
		return ~s[15:0];
	endfunction

	// Build a well-formed UDP frame; mode picks a mistake to inject.
	// mode 0 clean, 1 mac, 2 ethertype, 3 ip checksum, 4 version/ihl,
	// 5 protocol, 6 udp checksum, 7 port, 8 truncate, 9 short udp length
	task automatic build_frame(input int mode, input int plen, input int opt_words,
		input bit zero_ipchk, input bit bcast);
		logic [7:0] ip[], ud[];
		logic [31:0] s, us;
		logic [15:0] ulen_w, ic, uc;
		int ihl_v, cut;
		ihl_v = 5 + opt_words;
		ulen_w = 16'(plen + 8);
		frame_buf.delete();
		for (int i = 0; i < 6; i++)
			frame_buf.push_back(bcast ? 8'hff : cur_mac[47 - 8*i -: 8]);
		for (int i = 0; i < 6; i++) frame_buf.push_back($urandom_range(255));
		frame_buf.push_back(ETH_TYPE_HI);
		frame_buf.push_back(ETH_TYPE_LO);
		ip = new[4*ihl_v];
		foreach (ip[i]) ip[i] = $urandom_range(255);
		ip[0] = {4'd4, 4'(ihl_v)};
		ip[9] = PROTO_UDP;
		ip[10] = 0; ip[11] = 0;
		for (int i = 0; i < 4; i++) begin
			ip[12+i] = (cur_src != IP_ANY) ? cur_src[31 - 8*i -: 8] : $urandom_range(255);
			ip[16+i] = (cur_dst != IP_BROADCAST) ? cur_dst[31 - 8*i -: 8]
				: $urandom_range(255);
		end
		s = 0;
		for (int i = 0; i < 20; i += 2) s += {ip[i], ip[i+1]};
		ic = zero_ipchk ? 16'd0 : fold16(s);
		if (mode == 3 && ic == 0) ic = 16'h1234;
		else if (mode == 3) ic = ic ^ 16'h0001;
		ip[10] = ic[15:8]; ip[11] = ic[7:0];
		ud = new[8 + plen];
		foreach (ud[i]) ud[i] = $urandom_range(255);
		ud[2] = cur_port[15:8]; ud[3] = cur_port[7:0];
		ud[4] = ulen_w[15:8]; ud[5] = ulen_w[7:0];
		ud[6] = 0; ud[7] = 0;
		us = PROTO_UDP + ulen_w;
		for (int i = 12; i < 20; i += 2) us += {ip[i], ip[i+1]};
		for (int i = 0; i < 6; i += 2) us += {ud[i], ud[i+1]};
		for (int i = 8; i < 8 + plen; i++) us += (i % 2 == 0) ? {ud[i], 8'd0} : ud[i];
		uc = fold16(us);
		if (mode == 6) uc = ~uc;
		ud[6] = uc[15:8]; ud[7] = uc[7:0];
		if (mode == 7) ud[3] = ud[3] ^ 8'h01;
		if (mode == 9) ud[5] = $urandom_range(7);
		if (mode == 1) frame_buf[$urandom_range(5)] ^= 8'h01 << $urandom_range(7);
		if (mode == 2) frame_buf[12 + $urandom_range(1)] ^= 8'h01 << $urandom_range(7);
		if (mode == 4) ip[0] = $urandom_range(1) ? {4'(ip[0][7:4] ^ 4'h6), ip[0][3:0]}
			: {4'd4, 4'($urandom_range(4))};
		if (mode == 5) ip[9] = ip[9] ^ (8'h01 << $urandom_range(7));
		foreach (ip[i]) frame_buf.push_back(ip[i]);
		foreach (ud[i]) frame_buf.push_back(ud[i]);
		// trailing Ethernet padding past the UDP length
		repeat ($urandom_range(3)) frame_buf.push_back($urandom_range(255));
		if (mode == 8) begin
			cut = $urandom_range(frame_buf.size() - 1);
			while (frame_buf.size() > cut) void'(frame_buf.pop_back());
		end
	endtask

	task automatic random_frame();
		int mode, r;
		r = $urandom_range(99);
		if (r < 8) begin
			// noise frame
			frame_buf.delete();
			repeat ($urandom_range(1, 60)) frame_buf.push_back($urandom_range(255));
		end else begin
			mode = (r < 55) ? 0 : $urandom_range(1, 9);
			build_frame(mode, ($urandom_range(9) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 12), ($urandom_range(4) == 0) ? $urandom_range(1, 10)
				: 0, $urandom_range(3) == 0, $urandom_range(4) == 0);
		end
		send_frame();
	endtask

	task automatic random_config(input bit extreme);
		drain();
		write_reg(CFG_STATION_MAC, extreme ? 48'hffff_ffff_ffff
			: {$urandom, $urandom} & 48'hffff_ffff_ffff);
		write_reg(CFG_SOURCE_IP, $urandom_range(2) == 0 ? IP_ANY : $urandom);
		write_reg(CFG_DEST_IP, $urandom_range(2) == 0 ? IP_BROADCAST : $urandom);
		write_reg(CFG_DEST_PORT, extreme ? 16'hffff : $urandom_range(65535));
		write_reg(CFG_CAPTURE_LIM, extreme ? 12'd42 : $urandom_range(60, 4095));
	endtask

	initial begin
		in_ch.valid = 0; in_ch.frame_byte = 0; in_ch.end_of_frame = 0;
		cfg_ch.valid = 0; cfg_ch.index = CFG_STATION_MAC; cfg_ch.data = 0;
		cur_mac = 0; cur_src = IP_ANY; cur_dst = IP_BROADCAST; cur_port = 16'd67;
		cur_limit = 12'd1514;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: defaults, then every class of reject and special case.
		send_frame();                               // one-byte frame
		build_frame(0, 0, 0, 0, 1); send_frame();   // broadcast, zero payload
		build_frame(0, 3, 0, 1, 1); send_frame();   // odd length, no ip checksum
		drain();
		write_reg(CFG_STATION_MAC, 48'h0211_2233_4455);
		write_reg(CFG_SOURCE_IP, 32'hc0a8_0001);
		write_reg(CFG_DEST_IP, 32'h0a00_0001);
		write_reg(CFG_DEST_PORT, 16'hffff);
		write_reg(CFG_CAPTURE_LIM, 12'd2048);
		for (int m = 0; m < 10; m++) begin
			build_frame(m, 5, 0, 0, 0); send_frame();
		end
		build_frame(0, 7, 10, 0, 0); send_frame();  // maximum IPv4 options
		build_frame(0, 16, 0, 0, 0); send_frame();
		// all-zero and all-ones noise
		frame_buf.delete(); repeat (20) frame_buf.push_back(8'h00); send_frame();
		frame_buf.delete(); repeat (20) frame_buf.push_back(8'hff); send_frame();
		// capture limit at its low extreme and above the clamp
		drain();
		write_reg(CFG_CAPTURE_LIM, 12'd42);
		build_frame(0, 0, 0, 0, 0); send_frame();
		frame_buf.delete(); repeat (30) frame_buf.push_back($urandom_range(255));
		send_frame();
		drain();
		write_reg(CFG_CAPTURE_LIM, 12'hfff);
		build_frame(0, 2, 0, 0, 0); send_frame();
		drain();
		write_reg(CFG_CAPTURE_LIM, 12'd1514);
		write_reg(CFG_DEST_PORT, 16'h0000);
		build_frame(0, 1, 0, 0, 0); send_frame();

		// Random: three idling phases, settings changed between frames.
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin send_idle_pct = 81; recv_idle_pct = 20; end
			if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
			for (int c = 0; c < 3; c++) begin
				random_config(ph == 0 && c == 1);
				random_frame();
			end
		end
		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && verdicts_pending == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end
endmodule
